>>> sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // byte address of the attribute register
  localparam logic [1:0] ADDR_DEFAULT_ATTR = 2'd0;

  typedef struct packed {
    logic put;
    logic newline;
  } cursor_ctl_t;

endpackage

>>> sv/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tccw_cursor.sv
// ----------------------------------------------------------------------------
// tccw_cursor
// Cursor row and column, linear cell position and the scroll condition.
// ----------------------------------------------------------------------------
module tccw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tccw_pkg::cursor_ctl_t            ctl,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  pos,
  output logic                             wrap
);

  localparam int AW = $clog2(COLUMNS * ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [RW-1:0] row_next;
  logic [CW-1:0] col_next;
  logic          line_end;
  logic          row_last;

  assign line_end = ctl.newline || (col == COL_LAST);
  assign row_last = (row == ROW_LAST);
  assign wrap     = line_end && row_last;
  assign pos      = AW'(row) * COLS_A + AW'(col);

  always_comb begin
    row_next = row;
    col_next = col;
    if (ctl.put) begin
      if (line_end) begin
        col_next = '0;
        if (!row_last) begin
          row_next = row + RW'(1);
        end
      end else begin
        col_next = col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

>>> sv/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console writer: screen store, cursor, put with wrap and scroll, read.
// ----------------------------------------------------------------------------
// After reset the block clears the screen store to spaces with attribute 7,
// one cell a cycle, and holds busy high until the last cell is written.
// A command is taken when start is high and busy is low; its result appears
// one cycle later for exactly one cycle with done high, and must be taken
// then. That timing holds for a read or a put without scroll. A put that
// scrolls copies the store up by one line through the single store read
// port and write port, one cell a cycle, then blanks the bottom line before
// done is raised.
module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [7:0]  char_code,
  input  logic [10:0] read_index,
  output logic        done,
  output logic [10:0] cursor_position,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(CELLS - COLUMNS);
  localparam logic [15:0]   CELLS_W   = 16'(CELLS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_COPY  = 5'b00100,
    S_FILL  = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic [AW-1:0] cnt;
  logic [AW-1:0] cnt_next;
  logic [7:0]    default_attribute;
  logic          is_read;
  logic          hit;

  logic          accept;
  logic          put;
  logic          cfg_sel;
  logic [15:0]   ridx_w;
  logic [15:0]   pos_w;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  tccw_pkg::cursor_ctl_t cur_ctl;
  logic [AW-1:0]         pos;
  logic                  wrap;

  assign accept = start && !busy;
  assign put    = accept && (cmd == tccw_pkg::CMD_PUT);
  assign ridx_w = 16'(read_index);
  assign pos_w  = 16'(pos);

  assign cur_ctl.put     = put;
  assign cur_ctl.newline = (char_code == tccw_pkg::NEWLINE_CODE);

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk  (clk),
    .rst  (rst),
    .ctl  (cur_ctl),
    .pos  (pos),
    .wrap (wrap)
  );

  tccw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr == tccw_pkg::ADDR_DEFAULT_ATTR);
  assign prdata  = cfg_sel ? {24'b0, default_attribute} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= tccw_pkg::RESET_ATTR;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      default_attribute <= pwdata[7:0];
    end
  end

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = {default_attribute, tccw_pkg::SPACE_CODE};
    raddr = cnt + COLS_A;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::SPACE_CODE};
      end
      S_IDLE: begin
        raddr = ridx_w[AW-1:0];
        if (put && !cur_ctl.newline) begin
          we    = 1'b1;
          waddr = pos;
          wdata = {default_attribute, char_code};
        end
      end
      S_COPY: begin
        if (cnt == COPY_END) begin
          raddr = '0;
        end
        we    = (cnt != '0);
        waddr = cnt - AW'(1);
        wdata = rdata;
      end
      S_FILL: begin
        we = 1'b1;
      end
      S_RESP: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_CLEAR: begin
        cnt_next = cnt + AW'(1);
        if (cnt == LAST_CELL) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cnt_next   = '0;
          state_next = (put && wrap) ? S_COPY : S_RESP;
        end
      end
      S_COPY: begin
        if (cnt == COPY_END) begin
          state_next = S_FILL;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_FILL: begin
        if (cnt == LAST_CELL) begin
          state_next = S_RESP;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      is_read  <= 1'b0;
      hit      <= 1'b0;
      scrolled <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (accept) begin
        is_read  <= (cmd == tccw_pkg::CMD_READ);
        hit      <= (ridx_w < CELLS_W);
        scrolled <= put && wrap;
      end
    end
  end

  assign busy            = (state != S_IDLE);
  assign done            = (state == S_RESP);
  assign cursor_position = pos_w[10:0];
  assign cell_char       = (is_read && hit) ? rdata[7:0]  : 8'h00;
  assign cell_attr       = (is_read && hit) ? rdata[15:8] : 8'h00;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after an accepted command");

  a_read_keeps_cursor: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == tccw_pkg::CMD_READ) |=> $stable(cursor_position))
    else $error("read moved the cursor");

  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && we) |-> (waddr != raddr))
    else $error("scroll copy read and write hit the same cell");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat longer than one cycle");

endmodule
